// ===== sv/rwwf_pkg.sv =====
// Shared widths and types for the rank weighted window filter.
`timescale 1ns / 1ps
`default_nettype none
package rwwf_pkg;
  localparam int unsigned DataW = 16;
  localparam int unsigned VarW  = 16;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [VarW-1:0]         var_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_MAC    = 5'b00100,
    S_DSTART = 5'b01000,
    S_DIV    = 5'b10000
  } state_e;
endpackage
`default_nettype wire

// ===== sv/rwwf_sorter.sv =====
// Window kept as a row of cells sorted by variance, oldest first on ties.
`timescale 1ns / 1ps
`default_nettype none
module rwwf_sorter #(
  parameter int unsigned W = 20
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rwwf_pkg::data_t new_val_i,
  input  wire rwwf_pkg::var_t  new_var_i,
  output rwwf_pkg::data_t      sval_o [W],
  output rwwf_pkg::var_t       svar_o [W]
);
  import rwwf_pkg::*;
  localparam int unsigned AW = $clog2(W);

  data_t          val_q [W];
  var_t           var_q [W];
  logic [AW-1:0]  age_q [W];
  data_t          val_d [W];
  var_t           var_d [W];
  logic [AW-1:0]  age_d [W];
  data_t          cval [W-1];
  var_t           cvar [W-1];
  logic [AW-1:0]  cage [W-1];
  logic [W-1:0]   ge_rm;
  logic [W-2:0]   le;

  // Drop the oldest cell and compact the rest.
  always_comb begin
    ge_rm[0] = (age_q[0] == '0);
    for (int i = 1; i < W; i++) begin
      ge_rm[i] = ge_rm[i-1] | (age_q[i] == '0);
    end
    for (int i = 0; i < W-1; i++) begin
      if (ge_rm[i]) begin
        cval[i] = val_q[i+1];
        cvar[i] = var_q[i+1];
        cage[i] = age_q[i+1] - AW'(1);
      end else begin
        cval[i] = val_q[i];
        cvar[i] = var_q[i];
        cage[i] = age_q[i] - AW'(1);
      end
      le[i] = (cvar[i] <= new_var_i);
    end
  end

  // Insert the new sample after every cell with an equal or smaller variance.
  always_comb begin
    for (int j = 0; j < W; j++) begin
      if (j < W-1 && le[j < W-1 ? j : 0]) begin
        val_d[j] = cval[j < W-1 ? j : 0];
        var_d[j] = cvar[j < W-1 ? j : 0];
        age_d[j] = cage[j < W-1 ? j : 0];
      end else if (j == 0 || le[j > 0 ? j-1 : 0]) begin
        val_d[j] = new_val_i;
        var_d[j] = new_var_i;
        age_d[j] = AW'(W-1);
      end else begin
        val_d[j] = cval[j > 0 ? j-1 : 0];
        var_d[j] = cvar[j > 0 ? j-1 : 0];
        age_d[j] = cage[j > 0 ? j-1 : 0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < W; i++) begin
        val_q[i] <= '0;
        var_q[i] <= '0;
        age_q[i] <= AW'(i);
      end
    end else if (push_i) begin
      val_q <= val_d;
      var_q <= var_d;
      age_q <= age_d;
    end
  end

  assign sval_o = val_q;
  assign svar_o = var_q;
endmodule
`default_nettype wire

// ===== sv/rwwf_divider.sv =====
// Restoring divider, one quotient bit a cycle, signed dividend truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module rwwf_divider #(
  parameter int unsigned ACCW = 38,
  parameter int unsigned SW   = 21
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [ACCW-1:0] dividend_i,
  input  wire logic [SW-1:0]          divisor_i,
  output logic                        done_o,
  output rwwf_pkg::data_t             quotient_o
);
  import rwwf_pkg::*;
  localparam int unsigned CW = $clog2(ACCW + 1);

  logic            busy_q, done_q, neg_q;
  logic [ACCW-1:0] dvd_q, quo_q;
  logic [SW-1:0]   rem_q, div_q;
  logic [CW-1:0]   cnt_q;
  logic [SW:0]     trial, diff;
  logic            ge;
  logic [DataW-1:0] mag;

  assign trial = {rem_q, dvd_q[ACCW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(ACCW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[ACCW-1];
      dvd_q <= dividend_i[ACCW-1] ? ACCW'(-dividend_i) : ACCW'(dividend_i);
      rem_q <= '0;
      quo_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SW-1:0] : trial[SW-1:0];
      quo_q <= {quo_q[ACCW-2:0], ge};
      dvd_q <= {dvd_q[ACCW-2:0], 1'b0};
    end
  end

  assign mag        = quo_q[DataW-1:0];
  assign done_o     = done_q;
  assign quotient_o = (div_q == '0) ? '0 : (neg_q ? data_t'(-mag) : data_t'(mag));
endmodule
`default_nettype wire

// ===== sv/rank_weighted_window_filter.sv =====
// Top level: sorted window, shared multiply-accumulate and iterative divider.
// From request to result the sequencer runs: load, W + 1
//   multiply-accumulate steps, divider start, ACCW = 33 + clog2(W) divider steps, finish.
// A new request is taken only in the idle state, after the previous result has finished.
// The next request is taken while a finished result still waits at the output.
// Reset (rst_ni low, asynchronous) clears the window to zero values and variances.
`timescale 1ns / 1ps
`default_nettype none
module rank_weighted_window_filter #(
  parameter int unsigned W = 20
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire rwwf_pkg::data_t sample_value_i,
  input  wire rwwf_pkg::var_t  sample_variance_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output rwwf_pkg::data_t      weighted_value_o,
  output rwwf_pkg::data_t      least_spread_value_o
);
  import rwwf_pkg::*;
  localparam int unsigned AW   = $clog2(W);
  localparam int unsigned CW   = $clog2(W + 1);
  localparam int unsigned ACCW = 33 + AW;
  localparam int unsigned SW   = 16 + AW;
  localparam int unsigned PW   = DataW + VarW + 1;

  state_e state_q, state_d;
  logic   push;
  data_t  sval [W];
  var_t   svar [W];

  // Operand lines: values march toward index 0, variances toward index W-1,
  // so rank r meets the variance at rank W-1-r.
  data_t  a_q [W];
  var_t   b_q [W];
  logic [CW-1:0]          cnt_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [ACCW-1:0] acc_q;
  logic [SW-1:0]          sum_q;
  data_t                  ls_q;
  logic                   div_done;
  data_t                  quo;
  logic                   finish;
  logic                   out_valid_q;
  data_t                  wv_q, lso_q;

  assign push       = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign finish     = (state_q == S_DIV) && div_done && (!out_valid_q || out_ready_i);

  rwwf_sorter #(.W(W)) u_sorter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .new_val_i (sample_value_i),
    .new_var_i (sample_variance_i),
    .sval_o    (sval),
    .svar_o    (svar)
  );

  rwwf_divider #(.ACCW(ACCW), .SW(SW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DSTART),
    .dividend_i (acc_q),
    .divisor_i  (sum_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Sequencer: load the sorted window, run W products, then divide.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (push) state_d = S_LOAD;
      S_LOAD:   state_d = S_MAC;
      S_MAC:    if (cnt_q == CW'(W)) state_d = S_DSTART;
      S_DSTART: state_d = S_DIV;
      S_DIV:    if (finish) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD) begin
        cnt_q <= '0;
      end else if (state_q == S_MAC) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shared multiplier and accumulator.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      a_q   <= sval;
      b_q   <= svar;
      ls_q  <= sval[0];
      acc_q <= '0;
      sum_q <= '0;
    end else if (state_q == S_MAC) begin
      if (cnt_q < CW'(W)) begin
        prod_q <= PW'($signed(a_q[0]) * $signed({1'b0, b_q[W-1]}));
        sum_q  <= sum_q + SW'(b_q[W-1]);
        for (int i = 0; i < W-1; i++) begin
          a_q[i]   <= a_q[i+1];
          b_q[i+1] <= b_q[i];
        end
      end
      if (cnt_q != '0) begin
        acc_q <= acc_q + ACCW'(prod_q);
      end
    end
    if (finish) begin
      wv_q  <= quo;
      lso_q <= ls_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign weighted_value_o     = wv_q;
  assign least_spread_value_o = lso_q;

  a_push_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> state_q == S_LOAD)
    else $error("request accepted but sequencer did not load");
  a_rise_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DIV))
    else $error("result raised outside divide state");
  a_mac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC |-> cnt_q <= CW'(W))
    else $error("multiply count overran window");
endmodule
`default_nettype wire

// ===== verif/tb_rank_weighted_window_filter.sv =====
// Self-checking testbench for the rank weighted window filter with a built-in predictor.
`timescale 1ns / 1ps
module tb_rank_weighted_window_filter;
  import rwwf_pkg::*;

  localparam int unsigned W        = 20;
  localparam int          NDIR     = 25;
  localparam int          NTYPED   = 4;
  localparam int          NRAND    = 1750;
  localparam int          QUIET_AT = 1550;
  localparam int          LIMIT    = 1000000;

  typedef struct packed {
    data_t wval;
    data_t lval;
  } filt_res_t;

  typedef struct packed {
    data_t value;
    var_t  spread;
  } dir_row_t;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  data_t sample_value_i;
  var_t  sample_variance_i;
  logic  out_valid_o;
  logic  out_ready_i;
  data_t weighted_value_o;
  data_t least_spread_value_o;

  rank_weighted_window_filter #(.W(W)) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .sample_value_i      (sample_value_i),
    .sample_variance_i   (sample_variance_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .weighted_value_o    (weighted_value_o),
    .least_spread_value_o(least_spread_value_o)
  );

  // Predictor state: index 0 is the oldest entry.
  data_t     win_value [W];
  var_t      win_spread[W];
  filt_res_t filt_expected_q[$];
  filt_res_t typed_q[$];
  int        typed_seq_q[$];
  int        accept_cnt;
  int        mismatch_cnt;
  int        cycle_cnt;
  bit        quiet;
  bit        hold_req;
  dir_row_t  dir_tab[NDIR];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Shift the window and compute the least-spread value and rank-mirrored average.
  function automatic filt_res_t filter_window_step(data_t v, var_t s);
    filt_res_t   res;
    var_t        by_rank[W];
    int unsigned rank_of[W];
    int unsigned min_idx;
    longint      acc;
    longint      spread_sum;
    longint      quot;
    for (int i = 0; i < W - 1; i++) begin
      win_value[i]  = win_value[i+1];
      win_spread[i] = win_spread[i+1];
    end
    win_value[W-1]  = v;
    win_spread[W-1] = s;
    min_idx = 0;
    for (int i = 1; i < W; i++)
      if (win_spread[i] < win_spread[min_idx]) min_idx = i;
    spread_sum = 0;
    for (int j = 0; j < W; j++) begin
      rank_of[j] = 0;
      for (int k = 0; k < W; k++) begin
        if (win_spread[k] < win_spread[j]) rank_of[j]++;
        else if (win_spread[k] == win_spread[j] && k < j) rank_of[j]++;
      end
      by_rank[rank_of[j]] = win_spread[j];
      spread_sum += longint'(win_spread[j]);
    end
    acc = 0;
    for (int j = 0; j < W; j++)
      acc += longint'(win_value[j]) * longint'(by_rank[W-1-rank_of[j]]);
    quot = (spread_sum != 0) ? acc / spread_sum : 0;
    res.wval = quot[15:0];
    res.lval = win_value[min_idx];
    return res;
  endfunction

  // Monitor: check results first, then predict for any request taken at this edge.
  always @(posedge clk_i) begin
    filt_res_t got;
    filt_res_t want;
    filt_res_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.wval = weighted_value_o;
        got.lval = least_spread_value_o;
        if (filt_expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result wv=%0d ls=%0d", got.wval, got.lval);
        end else begin
          want = filt_expected_q.pop_front();
          if (got.wval !== want.wval || got.lval !== want.lval) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp wv=%0d ls=%0d got wv=%0d ls=%0d",
                       want.wval, want.lval, got.wval, got.lval);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        pred = filter_window_step(sample_value_i, sample_variance_i);
        // Rows with a hand-typed result take that value instead.
        if (typed_seq_q.size() != 0 && typed_seq_q[0] == accept_cnt) begin
          void'(typed_seq_q.pop_front());
          pred = typed_q.pop_front();
        end
        filt_expected_q.push_back(pred);
        accept_cnt <= accept_cnt + 1;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (399) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until taken; maybe idle afterwards.
  task automatic send_sample(data_t v, var_t s);
    int tgt;
    in_valid_i        <= 1'b1;
    sample_value_i    <= v;
    sample_variance_i <= s;
    tgt = accept_cnt + 1;
    do @(negedge clk_i); while (accept_cnt < tgt);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (filt_expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int   mode;
    int   run_len;
    int   n;
    var_t s;
    data_t v;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    sample_value_i    = '0;
    sample_variance_i = '0;
    accept_cnt        = 0;
    mismatch_cnt      = 0;
    cycle_cnt         = 0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    for (int i = 0; i < W; i++) begin
      win_value[i]  = '0;
      win_spread[i] = '0;
    end

    // Right after reset the zero entries hold every low rank: result is zero.
    dir_tab[0] = '{value: 16'sd32767, spread: 16'd0};
    dir_tab[1] = '{value: -16'sd32768, spread: 16'd65535};
    dir_tab[2] = '{value: 16'sd1, spread: 16'd1};
    dir_tab[3] = '{value: -16'sd1, spread: 16'd0};
    for (int i = 4; i < 12; i++) dir_tab[i] = '{value: -16'sd32768, spread: 16'd65535};
    for (int i = 12; i < 20; i++) dir_tab[i] = '{value: 16'sd32767, spread: 16'd0};
    dir_tab[20] = '{value: 16'sd5, spread: 16'd7};
    dir_tab[21] = '{value: -16'sd5, spread: 16'd7};
    dir_tab[22] = '{value: 16'sd100, spread: 16'd65535};
    dir_tab[23] = '{value: -16'sd1, spread: 16'd1};
    dir_tab[24] = '{value: 16'sd0, spread: 16'd32768};
    for (int i = 0; i < NTYPED; i++) begin
      typed_seq_q.push_back(i);
      typed_q.push_back('{wval: '0, lval: '0});
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_sample(dir_tab[i].value, dir_tab[i].spread);
    drain_results();

    // Random part: runs of full-range, tied, zero and extreme spreads.
    n = 0;
    while (n < NRAND) begin
      mode    = $urandom_range(0, 3);
      run_len = (mode == 2) ? W + $urandom_range(0, 4) : $urandom_range(1, 30);
      for (int k = 0; k < run_len && n < NRAND; k++) begin
        v = data_t'($urandom());
        case (mode)
          0: s = var_t'($urandom());
          1: s = var_t'($urandom_range(0, 3));
          2: s = '0;
          default: begin
            s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          end
        endcase
        if (n == 300) hold_req = 1'b1;
        if (n == 800) drain_results();
        if (n == QUIET_AT) quiet = 1'b1;
        send_sample(v, s);
        n++;
      end
    end

    drain_results();
    repeat (100) @(negedge clk_i);
    if (mismatch_cnt == 0 && filt_expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
